>>> rtl/rot4_pkg.sv
package rot4_pkg;

    localparam int DATA_WIDTH_DEF = 16;
    localparam int ROT_W          = 16;
    localparam int NUM_ROT        = 8;
    localparam int NUM_VEC        = 4;
    localparam int NUM_MID        = 8;
    localparam int FWD_TERMS      = 4;
    localparam int CFG_IDX_W      = 4;
    localparam int MID_SHIFT      = 4;
    localparam int OUT_SHIFT      = 26;

    localparam logic signed [ROT_W-1:0] ROT_ONE = 16'sh7FFF;

    typedef logic signed [ROT_W-1:0] rot_word_t;

    typedef enum logic [2:0] {
        RI_SCALAR,
        RI_XY,
        RI_XZ,
        RI_XW,
        RI_YZ,
        RI_YW,
        RI_ZW,
        RI_PSEUDO
    } rot_idx_t;

    typedef enum logic [1:0] {
        VI_X,
        VI_Y,
        VI_Z,
        VI_W
    } vec_idx_t;

    // Rotor times vector: four vector terms, then four trivector terms.
    localparam rot_idx_t FWD_ROT [NUM_MID][FWD_TERMS] = '{
        '{RI_SCALAR, RI_XY, RI_XZ, RI_XW},
        '{RI_SCALAR, RI_XY, RI_YZ, RI_YW},
        '{RI_SCALAR, RI_XZ, RI_YZ, RI_ZW},
        '{RI_SCALAR, RI_XW, RI_YW, RI_ZW},
        '{RI_XY, RI_XZ, RI_YZ, RI_PSEUDO},
        '{RI_XY, RI_XW, RI_YW, RI_PSEUDO},
        '{RI_XZ, RI_XW, RI_ZW, RI_PSEUDO},
        '{RI_YZ, RI_YW, RI_ZW, RI_PSEUDO}
    };

    localparam vec_idx_t FWD_VEC [NUM_MID][FWD_TERMS] = '{
        '{VI_X, VI_Y, VI_Z, VI_W},
        '{VI_Y, VI_X, VI_Z, VI_W},
        '{VI_Z, VI_X, VI_Y, VI_W},
        '{VI_W, VI_X, VI_Y, VI_Z},
        '{VI_Z, VI_Y, VI_X, VI_W},
        '{VI_W, VI_Y, VI_X, VI_Z},
        '{VI_W, VI_Z, VI_X, VI_Y},
        '{VI_W, VI_Z, VI_Y, VI_X}
    };

    // Bit j set means product j is subtracted.
    localparam logic [FWD_TERMS-1:0] FWD_NEG [NUM_MID] = '{
        4'b0000, 4'b0010, 4'b0110, 4'b1110,
        4'b0010, 4'b1010, 4'b0010, 4'b1010
    };

    // Terms times the reverse rotor, vector parts only.
    localparam rot_idx_t REV_ROT [NUM_VEC][NUM_MID] = '{
        '{RI_SCALAR, RI_XY, RI_XZ, RI_XW, RI_YZ, RI_YW, RI_ZW, RI_PSEUDO},
        '{RI_XY, RI_SCALAR, RI_YZ, RI_YW, RI_XZ, RI_XW, RI_PSEUDO, RI_ZW},
        '{RI_XZ, RI_YZ, RI_SCALAR, RI_ZW, RI_XY, RI_PSEUDO, RI_XW, RI_YW},
        '{RI_XW, RI_YW, RI_ZW, RI_SCALAR, RI_PSEUDO, RI_XY, RI_XZ, RI_YZ}
    };

    localparam logic [NUM_MID-1:0] REV_NEG [NUM_VEC] = '{
        8'b00000000, 8'b01110001, 8'b11000011, 8'b00010111
    };

endpackage

>>> rtl/rot4_fwd.sv
module rot4_fwd #(
    parameter int DATA_WIDTH = rot4_pkg::DATA_WIDTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  rot4_pkg::rot_word_t                  rotor [rot4_pkg::NUM_ROT],
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [DATA_WIDTH-1:0]         vec [rot4_pkg::NUM_VEC],
    output logic                                 mid_valid,
    input  logic                                 mid_ready,
    output logic signed [DATA_WIDTH+12:0]        mid [rot4_pkg::NUM_MID],
    output logic                                 mid_clip
);
    import rot4_pkg::*;

    localparam int PW = DATA_WIDTH + ROT_W;
    localparam int SW = DATA_WIDTH + 18;
    localparam int RW = SW - MID_SHIFT;
    localparam int MW = DATA_WIDTH + 13;
    localparam logic signed [SW-1:0] RND = SW'(1) <<< (MID_SHIFT - 1);
    localparam logic signed [MW-1:0] MID_MAX = {1'b0, {(MW-1){1'b1}}};
    localparam logic signed [MW-1:0] MID_MIN = {1'b1, {(MW-1){1'b0}}};

    logic                 en1;
    logic                 en2;
    logic                 en3;
    logic                 v1_reg;
    logic                 v2_reg;
    logic                 v3_reg;
    logic signed [PW-1:0] prod_reg [NUM_MID][FWD_TERMS];
    logic signed [PW-1:0] prod_next [NUM_MID][FWD_TERMS];
    logic signed [SW-1:0] sum_reg [NUM_MID];
    logic signed [SW-1:0] sum_next [NUM_MID];
    logic signed [MW-1:0] mid_reg [NUM_MID];
    logic signed [MW-1:0] mid_next [NUM_MID];
    logic                 clip_reg;
    logic                 clip_next;

    assign en3      = !v3_reg || mid_ready;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign in_ready = en1;

    always_comb
    begin
        for (int k = 0; k < NUM_MID; k++)
        begin
            for (int j = 0; j < FWD_TERMS; j++)
            begin
                prod_next[k][j] = PW'(rotor[FWD_ROT[k][j]]) * PW'(vec[FWD_VEC[k][j]]);
            end
        end
    end

    always_comb
    begin
        for (int k = 0; k < NUM_MID; k++)
        begin
            sum_next[k] = '0;
            for (int j = 0; j < FWD_TERMS; j++)
            begin
                if (FWD_NEG[k][j])
                begin
                    sum_next[k] = sum_next[k] - SW'(prod_reg[k][j]);
                end
                else
                begin
                    sum_next[k] = sum_next[k] + SW'(prod_reg[k][j]);
                end
            end
        end
    end

    always_comb
    begin
        logic signed [SW-1:0] rnd;
        logic signed [RW-1:0] shr;
        clip_next = 1'b0;
        for (int k = 0; k < NUM_MID; k++)
        begin
            rnd = sum_reg[k] + RND;
            shr = rnd[SW-1:MID_SHIFT];
            if (shr[RW-1] != shr[RW-2])
            begin
                clip_next   = 1'b1;
                mid_next[k] = shr[RW-1] ? MID_MIN : MID_MAX;
            end
            else
            begin
                mid_next[k] = shr[MW-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= in_valid;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
            if (en3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            prod_reg <= prod_next;
        end
        if (en2)
        begin
            sum_reg <= sum_next;
        end
        if (en3)
        begin
            mid_reg  <= mid_next;
            clip_reg <= clip_next;
        end
    end

    assign mid_valid = v3_reg;
    assign mid       = mid_reg;
    assign mid_clip  = clip_reg;

endmodule

>>> rtl/rot4_rev.sv
module rot4_rev #(
    parameter int DATA_WIDTH = rot4_pkg::DATA_WIDTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  rot4_pkg::rot_word_t                  rotor [rot4_pkg::NUM_ROT],
    input  logic                                 mid_valid,
    output logic                                 mid_ready,
    input  logic signed [DATA_WIDTH+12:0]        mid [rot4_pkg::NUM_MID],
    input  logic                                 mid_clip,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [DATA_WIDTH-1:0]         out_vec [rot4_pkg::NUM_VEC],
    output logic                                 out_clip
);
    import rot4_pkg::*;

    localparam int MW = DATA_WIDTH + 13;
    localparam int PW = MW + ROT_W;
    localparam int SW = DATA_WIDTH + 32;
    localparam int RW = SW - OUT_SHIFT;
    localparam int HW = RW - DATA_WIDTH + 1;
    localparam logic signed [SW-1:0] RND = SW'(1) <<< (OUT_SHIFT - 1);
    localparam logic signed [DATA_WIDTH-1:0] OUT_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic signed [DATA_WIDTH-1:0] OUT_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    logic                         en4;
    logic                         en5;
    logic                         en6;
    logic                         v4_reg;
    logic                         v5_reg;
    logic                         v6_reg;
    logic signed [PW-1:0]         prod_reg [NUM_VEC][NUM_MID];
    logic signed [PW-1:0]         prod_next [NUM_VEC][NUM_MID];
    logic signed [SW-1:0]         sum_reg [NUM_VEC];
    logic signed [SW-1:0]         sum_next [NUM_VEC];
    logic signed [DATA_WIDTH-1:0] res_reg [NUM_VEC];
    logic signed [DATA_WIDTH-1:0] res_next [NUM_VEC];
    logic                         clip4_reg;
    logic                         clip5_reg;
    logic                         clip6_reg;
    logic                         clip6_next;

    assign en6       = !v6_reg || out_ready;
    assign en5       = !v5_reg || en6;
    assign en4       = !v4_reg || en5;
    assign mid_ready = en4;

    always_comb
    begin
        for (int i = 0; i < NUM_VEC; i++)
        begin
            for (int j = 0; j < NUM_MID; j++)
            begin
                prod_next[i][j] = PW'(mid[j]) * PW'(rotor[REV_ROT[i][j]]);
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < NUM_VEC; i++)
        begin
            sum_next[i] = '0;
            for (int j = 0; j < NUM_MID; j++)
            begin
                if (REV_NEG[i][j])
                begin
                    sum_next[i] = sum_next[i] - SW'(prod_reg[i][j]);
                end
                else
                begin
                    sum_next[i] = sum_next[i] + SW'(prod_reg[i][j]);
                end
            end
        end
    end

    always_comb
    begin
        logic signed [SW-1:0] rnd;
        logic signed [RW-1:0] shr;
        logic [HW-1:0]        top;
        clip6_next = clip5_reg;
        for (int i = 0; i < NUM_VEC; i++)
        begin
            rnd = sum_reg[i] + RND;
            shr = rnd[SW-1:OUT_SHIFT];
            top = shr[RW-1:DATA_WIDTH-1];
            if ((&top) || !(|top))
            begin
                res_next[i] = shr[DATA_WIDTH-1:0];
            end
            else
            begin
                clip6_next  = 1'b1;
                res_next[i] = shr[RW-1] ? OUT_MIN : OUT_MAX;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else
        begin
            if (en4)
            begin
                v4_reg <= mid_valid;
            end
            if (en5)
            begin
                v5_reg <= v4_reg;
            end
            if (en6)
            begin
                v6_reg <= v5_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en4)
        begin
            prod_reg  <= prod_next;
            clip4_reg <= mid_clip;
        end
        if (en5)
        begin
            sum_reg   <= sum_next;
            clip5_reg <= clip4_reg;
        end
        if (en6)
        begin
            res_reg   <= res_next;
            clip6_reg <= clip6_next;
        end
    end

    assign out_valid = v6_reg;
    assign out_vec   = res_reg;
    assign out_clip  = clip6_reg;

endmodule

>>> rtl/rotor_4d_vector_rotation_top.sv
// Channel   Direction  Handshake                       Content
// s_axis    in         s_axis_tvalid / s_axis_tready   tdata: vec_x, vec_y, vec_z, vec_w
// m_axis    out        m_axis_tvalid / m_axis_tready   tdata: out_x..out_w; tuser: clipped
// cfg       in         cfg_valid / cfg_ready           cfg_index, cfg_data (rotor part)
//
// One item is accepted per cycle while the first stage has room, so a stalled output can hold back input.
// The six register stages are: forward products, forward sums, rounding to the intermediate
// terms, reverse products, reverse sums, and output rounding and saturation.
// Reset clears all valid bits and loads the identity rotor.
// A stalled output holds its item; each stage keeps loading while the stage after it has room.
module rotor_4d_vector_rotation_top #(
    parameter int DATA_WIDTH = rot4_pkg::DATA_WIDTH_DEF
) (
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  logic                                         s_axis_tvalid,
    output logic                                         s_axis_tready,
    // vec_x, vec_y, vec_z, vec_w, zero padding
    input  logic [((4*DATA_WIDTH+7)/8)*8-1:0]            s_axis_tdata,
    output logic                                         m_axis_tvalid,
    input  logic                                         m_axis_tready,
    // out_x, out_y, out_z, out_w, zero padding
    output logic [((4*DATA_WIDTH+7)/8)*8-1:0]            m_axis_tdata,
    // clipped
    output logic [0:0]                                   m_axis_tuser,
    input  logic                                         cfg_valid,
    output logic                                         cfg_ready,
    input  logic [rot4_pkg::CFG_IDX_W-1:0]               cfg_index,
    input  logic [rot4_pkg::ROT_W-1:0]                   cfg_data
);
    import rot4_pkg::*;

    localparam int TDATA_W = ((4 * DATA_WIDTH + 7) / 8) * 8;

    rot_word_t                    rotor_reg [NUM_ROT];
    logic signed [DATA_WIDTH-1:0] vec [NUM_VEC];
    logic signed [DATA_WIDTH+12:0] mid [NUM_MID];
    logic                         mid_valid;
    logic                         mid_ready;
    logic                         mid_clip;
    logic signed [DATA_WIDTH-1:0] out_vec [NUM_VEC];
    logic                         out_clip;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_ROT; i++)
            begin
                rotor_reg[i] <= (i == int'(RI_SCALAR)) ? ROT_ONE : '0;
            end
        end
        else if (cfg_valid && (cfg_index < CFG_IDX_W'(NUM_ROT)))
        begin
            rotor_reg[cfg_index[2:0]] <= cfg_data;
        end
    end

    always_comb
    begin
        for (int i = 0; i < NUM_VEC; i++)
        begin
            vec[i] = s_axis_tdata[i*DATA_WIDTH +: DATA_WIDTH];
        end
    end

    rot4_fwd #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_fwd (
        .clk       (clk),
        .rst_n     (rst_n),
        .rotor     (rotor_reg),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .vec       (vec),
        .mid_valid (mid_valid),
        .mid_ready (mid_ready),
        .mid       (mid),
        .mid_clip  (mid_clip)
    );

    rot4_rev #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_rev (
        .clk       (clk),
        .rst_n     (rst_n),
        .rotor     (rotor_reg),
        .mid_valid (mid_valid),
        .mid_ready (mid_ready),
        .mid       (mid),
        .mid_clip  (mid_clip),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_vec   (out_vec),
        .out_clip  (out_clip)
    );

    assign m_axis_tdata = TDATA_W'({out_vec[VI_W], out_vec[VI_Z], out_vec[VI_Y], out_vec[VI_X]});
    assign m_axis_tuser = out_clip;

endmodule

>>> tb/sv/rotor_4d_vector_rotation_top_tb.sv
`timescale 1ns / 1ps

module rotor_4d_vector_rotation_top_tb;

    import rot4_pkg::*;

    localparam int DW           = DATA_WIDTH_DEF;
    localparam int TDATA_W      = ((4 * DW + 7) / 8) * 8;
    localparam int MID_BITS     = DW + 13;
    localparam int CLK_PERIOD   = 20;
    localparam int RESET_CYCLES = 2;
    localparam int DRAIN_CYCLES = 12;
    localparam int HOLD_CYCLES  = 300;
    localparam int PHASE_ITEMS  = 150;
    localparam int NUM_PHASES   = 9;
    localparam int CYCLE_LIMIT  = 250000;
    localparam int MAX_REPORTS  = 10;

    localparam logic signed [DW-1:0] COORD_MAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] COORD_MIN = {1'b1, {(DW-1){1'b0}}};
    localparam rot_word_t            ROT_MIN   = 16'sh8000;

    typedef struct packed {
        logic signed [DW-1:0] w;
        logic signed [DW-1:0] z;
        logic signed [DW-1:0] y;
        logic signed [DW-1:0] x;
    } vec4_t;

    typedef struct packed {
        logic  clip;
        vec4_t coord;
    } rot_result_t;

    logic                 clk           = 1'b0;
    logic                 rst_n         = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [TDATA_W-1:0]   s_axis_tdata  = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b1;
    logic [TDATA_W-1:0]   m_axis_tdata;
    logic [0:0]           m_axis_tuser;
    logic                 cfg_valid     = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index     = '0;
    logic [ROT_W-1:0]     cfg_data      = '0;

    rot_word_t   rotor_q    [NUM_ROT];
    rot_word_t   next_rotor [NUM_ROT];
    vec4_t       vec_pending [$];
    rot_result_t rotated_q   [$];

    int  err_count   = 0;
    int  cycle_count = 0;
    int  src_gap     = 0;
    int  sink_gap    = 0;
    int  idle_odds   = 4;
    logic sink_hold  = 1'b0;

    rotor_4d_vector_rotation_top #(
        .DATA_WIDTH(DW)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic longint round_shift(input longint val, input int k);
        round_shift = (val + (longint'(1) << (k - 1))) >>> k;
    endfunction

    function automatic longint saturate(input longint val, input int bits, inout bit clip);
        longint hi;
        longint lo;
        hi = (longint'(1) << (bits - 1)) - 1;
        lo = -hi - 1;
        saturate = val;
        if (val > hi)
        begin
            saturate = hi;
            clip = 1'b1;
        end
        else if (val < lo)
        begin
            saturate = lo;
            clip = 1'b1;
        end
    endfunction

    function automatic longint mid_term(input longint q15, inout bit clip);
        mid_term = saturate(round_shift(q15, MID_SHIFT), MID_BITS, clip);
    endfunction

    function automatic rot_result_t rotate_vector(input vec4_t v);
        longint s, a, b, c, d, e, f, p;
        longint x, y, z, w;
        longint m0, m1, m2, m3, t0, t1, t2, t3;
        longint r [4];
        bit clip;
        rot_result_t res;
        clip = 1'b0;
        s = rotor_q[RI_SCALAR];
        a = rotor_q[RI_XY];
        b = rotor_q[RI_XZ];
        c = rotor_q[RI_XW];
        d = rotor_q[RI_YZ];
        e = rotor_q[RI_YW];
        f = rotor_q[RI_ZW];
        p = rotor_q[RI_PSEUDO];
        x = $signed(v.x);
        y = $signed(v.y);
        z = $signed(v.z);
        w = $signed(v.w);
        m0 = mid_term(s * x + a * y + b * z + c * w, clip);
        m1 = mid_term(s * y - a * x + d * z + e * w, clip);
        m2 = mid_term(s * z - b * x - d * y + f * w, clip);
        m3 = mid_term(s * w - c * x - e * y - f * z, clip);
        t0 = mid_term(a * z - b * y + d * x + p * w, clip);
        t1 = mid_term(a * w - c * y + e * x - p * z, clip);
        t2 = mid_term(b * w - c * z + f * x + p * y, clip);
        t3 = mid_term(d * w - e * z + f * y - p * x, clip);
        r[0] = m0 * s + m1 * a + m2 * b + m3 * c + t0 * d + t1 * e + t2 * f + t3 * p;
        r[1] = -m0 * a + m1 * s + m2 * d + m3 * e - t0 * b - t1 * c - t2 * p + t3 * f;
        r[2] = -m0 * b - m1 * d + m2 * s + m3 * f + t0 * a + t1 * p - t2 * c - t3 * e;
        r[3] = -m0 * c - m1 * e - m2 * f + m3 * s - t0 * p + t1 * a + t2 * b + t3 * d;
        for (int i = 0; i < 4; i++)
        begin
            r[i] = saturate(round_shift(r[i], OUT_SHIFT), DW, clip);
        end
        res.coord.x = r[0][DW-1:0];
        res.coord.y = r[1][DW-1:0];
        res.coord.z = r[2][DW-1:0];
        res.coord.w = r[3][DW-1:0];
        res.clip    = clip;
        return res;
    endfunction

    function automatic void push_vec(input longint x, input longint y,
                                     input longint z, input longint w);
        vec4_t v;
        v.x = x[DW-1:0];
        v.y = y[DW-1:0];
        v.z = z[DW-1:0];
        v.w = w[DW-1:0];
        vec_pending.push_back(v);
    endfunction

    function automatic logic signed [DW-1:0] rand_coord();
        case ($urandom_range(7))
            0: rand_coord = COORD_MAX;
            1: rand_coord = COORD_MIN;
            2: rand_coord = '0;
            3: rand_coord = DW'(int'($urandom_range(64)) - 32);
            default: rand_coord = DW'($urandom);
        endcase
    endfunction

    function automatic logic [CFG_IDX_W-1:0] junk_index();
        junk_index = CFG_IDX_W'($urandom_range(NUM_ROT, (1 << CFG_IDX_W) - 1));
    endfunction

    function automatic rot_word_t to_q15(input real val);
        to_q15 = rot_word_t'($rtoi(val * 32767.0));
    endfunction

    // A double rotation in two orthogonal planes gives a normalized rotor with a
    // pseudoscalar part.
    function automatic void make_double_rotor();
        real c1, s1, c2, s2;
        c1 = $cos($urandom_range(62831) / 20000.0);
        s1 = $sin($urandom_range(62831) / 20000.0);
        c2 = $cos($urandom_range(62831) / 20000.0);
        s2 = $sin($urandom_range(62831) / 20000.0);
        c1 = $sqrt(1.0 - s1 * s1) * (c1 < 0.0 ? -1.0 : 1.0);
        c2 = $sqrt(1.0 - s2 * s2) * (c2 < 0.0 ? -1.0 : 1.0);
        for (int i = 0; i < NUM_ROT; i++)
        begin
            next_rotor[i] = '0;
        end
        next_rotor[RI_SCALAR] = to_q15(c1 * c2);
        case ($urandom_range(2))
            0:
            begin
                next_rotor[RI_XY]     = to_q15(s1 * c2);
                next_rotor[RI_ZW]     = to_q15(c1 * s2);
                next_rotor[RI_PSEUDO] = to_q15(s1 * s2);
            end
            1:
            begin
                next_rotor[RI_XZ]     = to_q15(s1 * c2);
                next_rotor[RI_YW]     = to_q15(c1 * s2);
                next_rotor[RI_PSEUDO] = to_q15(-s1 * s2);
            end
            default:
            begin
                next_rotor[RI_XW]     = to_q15(s1 * c2);
                next_rotor[RI_YZ]     = to_q15(c1 * s2);
                next_rotor[RI_PSEUDO] = to_q15(s1 * s2);
            end
        endcase
    endfunction

    function automatic void fill_rotor(input rot_word_t val);
        for (int i = 0; i < NUM_ROT; i++)
        begin
            next_rotor[i] = val;
        end
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input rot_word_t val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        if (idx < CFG_IDX_W'(NUM_ROT)) rotor_q[idx[2:0]] = val;
    endtask

    // Writes to unused indexes are mixed in; they must leave the rotor alone.
    task automatic load_rotor();
        logic [CFG_IDX_W-1:0] idx;
        for (int i = 0; i < NUM_ROT; i++)
        begin
            if ($urandom_range(3) == 0) write_reg(junk_index(), rot_word_t'($urandom));
            idx = CFG_IDX_W'(i);
            write_reg(idx, next_rotor[i]);
        end
        write_reg(junk_index(), rot_word_t'($urandom));
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        while (vec_pending.size() != 0 || s_axis_tvalid || rotated_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic flag_error(input string msg);
        err_count++;
        if (err_count <= MAX_REPORTS) $display("mismatch: %s", msg);
    endtask

    always @(posedge clk)
    begin : vec_driver
        logic nxt_valid;
        if (rst_n)
        begin
            nxt_valid = s_axis_tvalid;
            if (s_axis_tvalid && s_axis_tready)
            begin
                rotated_q.push_back(rotate_vector(vec4_t'(s_axis_tdata)));
                nxt_valid = 1'b0;
            end
            if (!nxt_valid)
            begin
                if (src_gap > 0)
                begin
                    src_gap--;
                end
                else if (vec_pending.size() != 0)
                begin
                    if (idle_odds != 0 && $urandom_range(idle_odds - 1) == 0)
                    begin
                        src_gap = $urandom_range(13);
                    end
                    else
                    begin
                        s_axis_tdata <= vec_pending.pop_front();
                        nxt_valid = 1'b1;
                    end
                end
            end
            s_axis_tvalid <= nxt_valid;
        end
    end

    always @(posedge clk)
    begin : result_monitor
        rot_result_t got;
        rot_result_t want;
        logic nxt_ready;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.coord = m_axis_tdata[4*DW-1:0];
                got.clip  = m_axis_tuser[0];
                if (rotated_q.size() == 0)
                begin
                    flag_error($sformatf("unexpected result x=%0d y=%0d z=%0d w=%0d clip=%0b",
                        got.coord.x, got.coord.y, got.coord.z, got.coord.w, got.clip));
                end
                else
                begin
                    want = rotated_q.pop_front();
                    if (got.coord.x !== want.coord.x || got.coord.y !== want.coord.y ||
                        got.coord.z !== want.coord.z || got.coord.w !== want.coord.w ||
                        got.clip !== want.clip)
                    begin
                        flag_error($sformatf(
                            "expected %0d %0d %0d %0d clip=%0b, got %0d %0d %0d %0d clip=%0b",
                            want.coord.x, want.coord.y, want.coord.z, want.coord.w, want.clip,
                            got.coord.x, got.coord.y, got.coord.z, got.coord.w, got.clip));
                    end
                end
            end
            if (sink_hold)
            begin
                nxt_ready = 1'b0;
            end
            else if (sink_gap > 0)
            begin
                sink_gap--;
                nxt_ready = 1'b0;
            end
            else if (idle_odds != 0 && $urandom_range(idle_odds - 1) == 0)
            begin
                sink_gap = $urandom_range(13);
                nxt_ready = 1'b0;
            end
            else
            begin
                nxt_ready = 1'b1;
            end
            m_axis_tready <= nxt_ready;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        for (int i = 0; i < NUM_ROT; i++)
        begin
            rotor_q[i] = '0;
        end
        rotor_q[RI_SCALAR] = ROT_ONE;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // The rotor after reset is the identity; ties of the rounding show up at
        // odd multiples of eight.
        push_vec(0, 0, 0, 0);
        push_vec(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
        push_vec(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN);
        push_vec(COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN);
        push_vec(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX);
        push_vec(8, -8, 24, -24);
        push_vec(1, -1, 7, -9);
        push_vec(-1, 0, 0, 0);
        drain();

        // An unnormalized rotor drives the intermediate terms and outputs into
        // saturation.
        fill_rotor(ROT_MIN);
        load_rotor();
        push_vec(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN);
        push_vec(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
        push_vec(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX);
        push_vec(COORD_MAX, 0, 0, COORD_MIN);
        push_vec(1, 1, 1, 1);
        drain();

        fill_rotor('0);
        next_rotor[RI_SCALAR] = 16'sd16384;
        next_rotor[RI_XY]     = 16'sd16384;
        next_rotor[RI_ZW]     = 16'sd16384;
        next_rotor[RI_PSEUDO] = 16'sd16384;
        load_rotor();
        push_vec(COORD_MAX, 0, 0, 0);
        push_vec(0, COORD_MIN, 0, 0);
        push_vec(0, 0, COORD_MAX, 0);
        push_vec(0, 0, 0, COORD_MIN);
        push_vec(1000, -2000, 3000, -4000);
        drain();

        for (int k = 0; k < NUM_PHASES; k++)
        begin
            case (k)
                0: fill_rotor(ROT_ONE);
                1: fill_rotor(ROT_MIN);
                2, 6:
                begin
                    for (int i = 0; i < NUM_ROT; i++)
                    begin
                        next_rotor[i] = rot_word_t'($urandom);
                    end
                end
                default: make_double_rotor();
            endcase
            load_rotor();
            if (k == NUM_PHASES - 1 || k == 5) idle_odds <= 0;
            else idle_odds <= $urandom_range(3, 12);
            if (k == 3)
            begin
                fork
                    begin
                        sink_hold <= 1'b1;
                        repeat (HOLD_CYCLES) @(posedge clk);
                        sink_hold <= 1'b0;
                    end
                join_none
            end
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                push_vec(rand_coord(), rand_coord(), rand_coord(), rand_coord());
            end
            drain();
        end

        if (err_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
